// ===== hw/rtl/mbsg_pkg.sv =====
`timescale 1ns / 1ps

package mbsg_pkg;

  localparam int FRAME_W = 8;
  localparam int COORD_W = 7;
  localparam int POS_W = 10;
  localparam int SIDE_LEN = 124;
  localparam int PERIM = 496;
  localparam int START_POS = 372;
  localparam int INSET = 2;
  localparam int THICK = 4;
  localparam int SCREEN = 128;
  localparam int DEF_ANIM_FRAMES = 20;
  localparam int DEF_MAX_RECTS = 2;

  typedef logic [1:0] side_t;

  // walking order of the border path
  localparam side_t SIDE_TOP    = 2'd0;
  localparam side_t SIDE_RIGHT  = 2'd1;
  localparam side_t SIDE_BOTTOM = 2'd2;
  localparam side_t SIDE_LEFT   = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } rect_t;

  // side order: top, right, bottom, left
  function automatic rect_t make_rect(side_t side, logic [COORD_W-1:0] off,
                                      logic [COORD_W-1:0] len);
    rect_t r;
    r = '0;
    case (side)
      SIDE_TOP: begin
        r.x = COORD_W'(INSET) + off;
        r.y = COORD_W'(INSET);
        r.w = len;
        r.h = COORD_W'(THICK);
      end
      SIDE_RIGHT: begin
        r.x = COORD_W'(SCREEN - INSET - THICK);
        r.y = COORD_W'(INSET) + off;
        r.w = COORD_W'(THICK);
        r.h = len;
      end
      SIDE_BOTTOM: begin
        r.x = COORD_W'(SCREEN - INSET) - off - len;
        r.y = COORD_W'(SCREEN - INSET - THICK);
        r.w = len;
        r.h = COORD_W'(THICK);
      end
      default: begin
        r.x = COORD_W'(INSET);
        r.y = COORD_W'(SCREEN - INSET) - off - len;
        r.w = COORD_W'(THICK);
        r.h = len;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/moving_border_segment_generator_top.sv =====
`timescale 1ns / 1ps

// moving border segment generator
// input channel: one frame number per item (frame, in_valid/in_ready)
// output channel: one rectangle per item (rect_x, rect_y, rect_width,
//   rect_height, last; out_valid/out_ready), one or two per frame
// the frame is folded modulo ANIM_FRAMES and a 124-pixel line is placed on
//   the 496-pixel border path, split at a corner into two rectangles
// the start point comes from a constant table indexed by the frame; one
//   shared compare-and-subtract unit then walks it past whole sides, one
//   side a cycle, to find the starting side and the offset along it
// the first rectangle is registered once the walk ends; the second (if any)
//   follows on the cycle after the first is taken
// a frame is walked and its rectangles sent before the next is accepted;
//   in_ready is low from acceptance until the last rectangle of the frame is
//   taken
// a stalled receiver holds the rectangle and its last flag steady in the
//   output register; nothing new is accepted meanwhile
// reset (rst, synchronous) returns the sequencer to idle, drops out_valid
//   and raises in_ready on the next cycle
module moving_border_segment_generator_top
  import mbsg_pkg::*;
#(
  parameter int ANIM_FRAMES = DEF_ANIM_FRAMES,
  parameter int MAX_RECTS   = DEF_MAX_RECTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAME_W-1:0] frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] rect_x,
  output logic [COORD_W-1:0] rect_y,
  output logic [COORD_W-1:0] rect_width,
  output logic [COORD_W-1:0] rect_height,
  output logic               last
);

  localparam int FRAME_VALS = 2 ** FRAME_W;
  localparam bit TWO_OK = (MAX_RECTS >= 2);

  // start point of every frame value, measured along the path from the
  // foot of the left side
  function automatic logic [FRAME_VALS*POS_W-1:0] build_start_tab();
    logic [FRAME_VALS*POS_W-1:0] tab;
    int folded;
    tab = '0;
    for (int i = 0; i < FRAME_VALS; i++) begin
      folded = i % ANIM_FRAMES;
      tab[i*POS_W +: POS_W] = POS_W'((folded * PERIM) / ANIM_FRAMES);
    end
    return tab;
  endfunction

  localparam logic [FRAME_VALS*POS_W-1:0] START_TAB = build_start_tab();

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;

  // position left to walk and the side reached so far; after the first
  // piece side_r and off_r describe the pending second piece
  logic [POS_W-1:0]   pos;
  side_t              side_r;
  logic [COORD_W-1:0] off_r;
  logic               pending;

  logic [POS_W-1:0]   tab_pos;
  logic               walk_ge;
  logic [POS_W-1:0]   walk_diff;
  logic [COORD_W-1:0] seg_off;
  logic               seg_two;

  rect_t out_rect;

  assign tab_pos = START_TAB[frame*POS_W +: POS_W];

  // shared compare and subtract against one side length
  always_comb begin
    walk_ge   = (pos >= POS_W'(SIDE_LEN));
    walk_diff = pos - POS_W'(SIDE_LEN);
    seg_off   = pos[COORD_W-1:0];
    // a line starting mid-side runs over the next corner
    seg_two   = TWO_OK && (seg_off != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos    <= tab_pos;
            side_r <= SIDE_LEFT;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_ge) begin
            // past the next corner: step onto the following side
            pos    <= walk_diff;
            side_r <= side_r + 2'd1;
          end else begin
            out_rect <= make_rect(side_r, seg_off, COORD_W'(SIDE_LEN) - seg_off);
            last     <= !seg_two;
            pending  <= seg_two;
            side_r   <= side_r + 2'd1;
            off_r    <= seg_off;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (pending) begin
              // the rest of the line starts at the corner of the next side
              out_rect <= make_rect(side_r, '0, off_r);
              last     <= 1'b1;
              pending  <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign rect_x      = out_rect.x;
  assign rect_y      = out_rect.y;
  assign rect_width  = out_rect.w;
  assign rect_height = out_rect.h;

endmodule

// ===== hw/rtl/mbsg_checker.sv =====
`timescale 1ns / 1ps

module mbsg_checker
  import mbsg_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] rect_x,
  input logic [COORD_W-1:0] rect_y,
  input logic [COORD_W-1:0] rect_width,
  input logic [COORD_W-1:0] rect_height,
  input logic               last
);

  // busy after taking a frame
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a frame while still busy");

  // no new frame while rectangles are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready for a frame while a rectangle is pending");

  // second rectangle follows the first at once
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("rectangle without last not followed by another");

  // a stalled rectangle holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rect_x) && $stable(rect_y)
      && $stable(rect_width) && $stable(rect_height) && $stable(last))
    else $error("stalled rectangle changed");

  // every piece of the border is one thickness across
  a_thickness: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rect_width == COORD_W'(THICK) || rect_height == COORD_W'(THICK))
    else $error("rectangle not border thickness");

endmodule

bind moving_border_segment_generator_top mbsg_checker u_mbsg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .rect_x      (rect_x),
  .rect_y      (rect_y),
  .rect_width  (rect_width),
  .rect_height (rect_height),
  .last        (last)
);
